// ===== rtl/core/bmlt_pkg.sv =====
// Shared types and codes for the bounded multi-list table.
// Holds the command and status encodings; no dependencies.
package bmlt_pkg;

   localparam int MODE_W   = 4;
   localparam int SLOT_W   = 4;
   localparam int AMOUNT_W = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 4;
   localparam int CNT_W    = 4;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam mode_type MODE_CREATE      = 4'd0;
   localparam mode_type MODE_APPEND      = 4'd1;
   localparam mode_type MODE_DROP_LAST   = 4'd2;
   localparam mode_type MODE_DROP_VALUE  = 4'd3;
   localparam mode_type MODE_RESIZE      = 4'd4;
   localparam mode_type MODE_COUNT       = 4'd5;
   localparam mode_type MODE_READ        = 4'd6;
   localparam mode_type MODE_READ_SORTED = 4'd7;
   localparam mode_type MODE_READ_ALL    = 4'd8;
   localparam mode_type MODE_ALL_SORTED  = 4'd9;

   localparam status_type ST_OK           = 4'd0;
   localparam status_type ST_BAD_SLOT     = 4'd1;
   localparam status_type ST_NO_LIST      = 4'd2;
   localparam status_type ST_EXISTS       = 4'd3;
   localparam status_type ST_BAD_SIZE     = 4'd4;
   localparam status_type ST_NO_MEMORY    = 4'd5;
   localparam status_type ST_FULL         = 4'd6;
   localparam status_type ST_EMPTY        = 4'd7;
   localparam status_type ST_NOT_FOUND    = 4'd8;
   localparam status_type ST_BAD_NEW_SIZE = 4'd9;
   localparam status_type ST_ALL_EMPTY    = 4'd10;

endpackage

// ===== rtl/core/bounded_multi_list_table_top.sv =====
// Top level of the bounded multi-list table: command decode, sequencer and
// list bookkeeping. Depends on bmlt_pkg and bmlt_store.
//
// Usage: a command transfers on the req_ channel when req_valid is high and
// req_stall is low. The block holds req_stall high while it works on one
// command. Each command returns one or more rsp_ transfers; the final one has
// rsp_last set. Unknown modes are dropped with no response.
// Simple commands are decided in the check state and answer with one transfer.
// Drop-by-value walks the positions of the list until it finds the value,
// then shifts the tail down by one element. A plain read scans every position
// and reads each stored element, skipping empty positions. A sorted read runs
// one full scan pass per emitted element (up to NUM_LISTS*MAX_CAPACITY
// positions each), so its run time grows with the square of the element count;
// the element store has a single read port for all of these scans.
// Reset clears all list descriptors (existence, capacity, count); the element
// store needs no clearing. When the receiver stalls, the pending response
// holds in the output register and the sequencer waits.
module bounded_multi_list_table_top
   import bmlt_pkg::*;
#(
   parameter int NUM_LISTS    = 8,
   parameter int MAX_CAPACITY = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [SLOT_W-1:0]          req_slot,
   input  logic signed [AMOUNT_W-1:0] req_amount,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_has_value,
   output logic signed [DATA_W-1:0]   rsp_data_out,
   output logic [CNT_W-1:0]           rsp_count_out,
   output logic                       rsp_last
);

   localparam int DEPTH = NUM_LISTS * MAX_CAPACITY;
   localparam int SW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int IW    = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(DEPTH + 1);
   localparam int KW    = DATA_W + AW;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_CHECK    = 8'b0000_0010,
      S_SCAN_RD  = 8'b0000_0100,
      S_SCAN_CMP = 8'b0000_1000,
      S_NEXT     = 8'b0001_0000,
      S_EMIT     = 8'b0010_0000,
      S_SHIFT_RD = 8'b0100_0000,
      S_SHIFT_WR = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [MODE_W-1:0]          mode_ff, mode_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic signed [AMOUNT_W-1:0] amount_ff, amount_in;
   logic [DATA_W-1:0]          value_ff, value_in;
   logic [SW-1:0]              cur_slot_ff, cur_slot_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic [NW-1:0]              n_total_ff, n_total_in;
   logic [NW-1:0]              emit_cnt_ff, emit_cnt_in;
   logic                       prev_valid_ff, prev_valid_in;
   logic [KW-1:0]              prev_key_ff, prev_key_in;
   logic                       best_valid_ff, best_valid_in;
   logic [KW-1:0]              best_key_ff, best_key_in;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_has_ff, res_has_in;
   logic [DATA_W-1:0]   res_data_ff, res_data_in;
   logic [CNT_W-1:0]    res_count_ff, res_count_in;
   logic                res_last_ff, res_last_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_has_ff, rsp_has_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic             exists_ff [NUM_LISTS];
   logic             exists_in [NUM_LISTS];
   logic [CNT_W-1:0] cap_ff    [NUM_LISTS];
   logic [CNT_W-1:0] cap_in    [NUM_LISTS];
   logic [CNT_W-1:0] count_ff  [NUM_LISTS];
   logic [CNT_W-1:0] count_in  [NUM_LISTS];

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   logic             cur_exists;
   logic [CNT_W-1:0] cur_cap, cur_cnt;
   logic [AW-1:0]    cur_addr;
   logic [NW-1:0]    n_sum;
   logic             scope_all, sorted_mode, slot_ok, pos_valid, out_free, load_rsp;
   logic [KW-1:0]    cand_key;
   logic signed [AMOUNT_W:0] new_cap;
   logic [NW-1:0]    emit_next;

   bmlt_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign cur_exists  = exists_ff[cur_slot_ff];
   assign cur_cap     = cap_ff[cur_slot_ff];
   assign cur_cnt     = count_ff[cur_slot_ff];
   assign cur_addr    = AW'(AW'(cur_slot_ff) * AW'(MAX_CAPACITY)) + AW'(idx_ff);
   assign scope_all   = (mode_ff == MODE_READ_ALL) || (mode_ff == MODE_ALL_SORTED);
   assign sorted_mode = (mode_ff == MODE_READ_SORTED) || (mode_ff == MODE_ALL_SORTED);
   assign slot_ok     = (slot_ff >= SLOT_W'(1)) && (slot_ff <= SLOT_W'(NUM_LISTS));
   assign pos_valid   = cur_exists && (CNT_W'(idx_ff) < cur_cnt);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign load_rsp    = (state_ff == S_EMIT) && out_free;
   // Sort key: value with its sign bit flipped, then the store position, so
   // equal values come out in buffer order.
   assign cand_key    = {~rd_data[DATA_W-1], rd_data[DATA_W-2:0], cur_addr};
   assign new_cap     = $signed({3'b000, cur_cap}) + (AMOUNT_W+1)'(amount_ff);
   assign emit_next   = emit_cnt_ff + NW'(1);

   always_comb begin
      n_sum = '0;
      for (int k = 0; k < NUM_LISTS; k++) begin
         if (exists_ff[k]) begin
            n_sum = n_sum + NW'(count_ff[k]);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      slot_in       = slot_ff;
      amount_in     = amount_ff;
      value_in      = value_ff;
      cur_slot_in   = cur_slot_ff;
      idx_in        = idx_ff;
      n_total_in    = n_total_ff;
      emit_cnt_in   = emit_cnt_ff;
      prev_valid_in = prev_valid_ff;
      prev_key_in   = prev_key_ff;
      best_valid_in = best_valid_ff;
      best_key_in   = best_key_ff;
      res_status_in = res_status_ff;
      res_has_in    = res_has_ff;
      res_data_in   = res_data_ff;
      res_count_in  = res_count_ff;
      res_last_in   = res_last_ff;
      exists_in     = exists_ff;
      cap_in        = cap_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_addr;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = cur_addr;

      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && (req_mode <= MODE_ALL_SORTED)) begin
               mode_in     = req_mode;
               slot_in     = req_slot;
               amount_in   = req_amount;
               value_in    = req_value;
               cur_slot_in = SW'(req_slot - SLOT_W'(1));
               state_in    = S_CHECK;
            end
         end

         S_CHECK: begin
            res_status_in = ST_OK;
            res_has_in    = 1'b0;
            res_data_in   = '0;
            res_count_in  = '0;
            res_last_in   = 1'b1;
            state_in      = S_EMIT;
            idx_in        = '0;
            emit_cnt_in   = '0;
            prev_valid_in = 1'b0;
            best_valid_in = 1'b0;
            if (scope_all) begin
               cur_slot_in = '0;
               if (n_sum == '0) begin
                  res_status_in = ST_ALL_EMPTY;
               end else begin
                  n_total_in = n_sum;
                  state_in   = S_SCAN_RD;
               end
            end else if (!slot_ok) begin
               res_status_in = ST_BAD_SLOT;
            end else if (mode_ff == MODE_CREATE) begin
               if (cur_exists) begin
                  res_status_in = ST_EXISTS;
               end else if (amount_ff < $signed(AMOUNT_W'(1))) begin
                  res_status_in = ST_BAD_SIZE;
               end else if (amount_ff > $signed(AMOUNT_W'(MAX_CAPACITY))) begin
                  res_status_in = ST_NO_MEMORY;
               end else begin
                  exists_in[cur_slot_ff] = 1'b1;
                  cap_in[cur_slot_ff]    = CNT_W'(amount_ff);
                  count_in[cur_slot_ff]  = '0;
               end
            end else if (!cur_exists) begin
               res_status_in = ST_NO_LIST;
            end else begin
               unique case (mode_ff)
                  MODE_APPEND: begin
                     if ((cur_cnt >= cur_cap) || (cur_cnt >= CNT_W'(MAX_CAPACITY))) begin
                        res_status_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(AW'(cur_slot_ff) * AW'(MAX_CAPACITY))
                                  + AW'(cur_cnt[IW-1:0]);
                        wr_data = value_ff;
                        count_in[cur_slot_ff] = cur_cnt + CNT_W'(1);
                     end
                  end
                  MODE_DROP_LAST: begin
                     if (cur_cnt == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        count_in[cur_slot_ff] = cur_cnt - CNT_W'(1);
                     end
                  end
                  MODE_DROP_VALUE: begin
                     if (cur_cnt == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  MODE_RESIZE: begin
                     if (new_cap < $signed((AMOUNT_W+1)'(1))) begin
                        res_status_in = ST_BAD_NEW_SIZE;
                     end else if (new_cap > $signed((AMOUNT_W+1)'(MAX_CAPACITY))) begin
                        res_status_in = ST_NO_MEMORY;
                     end else begin
                        cap_in[cur_slot_ff] = CNT_W'(new_cap);
                        if (cur_cnt > CNT_W'(new_cap)) begin
                           count_in[cur_slot_ff] = CNT_W'(new_cap);
                        end
                     end
                  end
                  MODE_COUNT: begin
                     if (cur_cnt == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        res_count_in = cur_cnt;
                     end
                  end
                  default: begin
                     // Single-list reads; an empty list answers once with no data.
                     if (cur_cnt != '0) begin
                        n_total_in = NW'(cur_cnt);
                        state_in   = S_SCAN_RD;
                     end
                  end
               endcase
            end
         end

         S_SCAN_RD: begin
            if (pos_valid) begin
               rd_en    = 1'b1;
               state_in = S_SCAN_CMP;
            end else begin
               state_in = S_NEXT;
            end
         end

         S_SCAN_CMP: begin
            state_in = S_NEXT;
            if (mode_ff == MODE_DROP_VALUE) begin
               if (rd_data == value_ff) begin
                  state_in = S_SHIFT_RD;
               end
            end else if (sorted_mode) begin
               if ((!prev_valid_ff || (cand_key > prev_key_ff))
                   && (!best_valid_ff || (cand_key < best_key_ff))) begin
                  best_valid_in = 1'b1;
                  best_key_in   = cand_key;
               end
            end else begin
               res_status_in = ST_OK;
               res_has_in    = 1'b1;
               res_data_in   = rd_data;
               res_count_in  = '0;
               res_last_in   = (emit_next == n_total_ff);
               emit_cnt_in   = emit_next;
               state_in      = S_EMIT;
            end
         end

         S_NEXT: begin
            if (idx_ff != IW'(MAX_CAPACITY - 1)) begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_SCAN_RD;
            end else if (scope_all && (cur_slot_ff != SW'(NUM_LISTS - 1))) begin
               idx_in      = '0;
               cur_slot_in = cur_slot_ff + SW'(1);
               state_in    = S_SCAN_RD;
            end else if (mode_ff == MODE_DROP_VALUE) begin
               res_status_in = ST_NOT_FOUND;
               res_has_in    = 1'b0;
               res_data_in   = '0;
               res_count_in  = '0;
               res_last_in   = 1'b1;
               state_in      = S_EMIT;
            end else if (sorted_mode && best_valid_ff) begin
               // End of a pass: the smallest key above the previous one goes out.
               res_status_in = ST_OK;
               res_has_in    = 1'b1;
               res_data_in   = {~best_key_ff[KW-1], best_key_ff[KW-2:AW]};
               res_count_in  = '0;
               res_last_in   = (emit_next == n_total_ff);
               emit_cnt_in   = emit_next;
               prev_valid_in = 1'b1;
               prev_key_in   = best_key_ff;
               state_in      = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_has_in    = res_has_ff;
               rsp_data_in   = res_data_ff;
               rsp_count_in  = res_count_ff;
               rsp_last_in   = res_last_ff;
               if (res_last_ff) begin
                  state_in = S_IDLE;
               end else if (sorted_mode) begin
                  idx_in        = '0;
                  best_valid_in = 1'b0;
                  if (scope_all) begin
                     cur_slot_in = '0;
                  end
                  state_in = S_SCAN_RD;
               end else begin
                  state_in = S_NEXT;
               end
            end
         end

         S_SHIFT_RD: begin
            if ((CNT_W'(idx_ff) + CNT_W'(1)) < cur_cnt) begin
               rd_en    = 1'b1;
               rd_addr  = cur_addr + AW'(1);
               state_in = S_SHIFT_WR;
            end else begin
               count_in[cur_slot_ff] = cur_cnt - CNT_W'(1);
               res_status_in = ST_OK;
               res_has_in    = 1'b0;
               res_data_in   = '0;
               res_count_in  = '0;
               res_last_in   = 1'b1;
               state_in      = S_EMIT;
            end
         end

         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = cur_addr;
            wr_data  = rd_data;
            idx_in   = idx_ff + IW'(1);
            state_in = S_SHIFT_RD;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_LISTS; k++) begin
            exists_ff[k] <= 1'b0;
            cap_ff[k]    <= '0;
            count_ff[k]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         exists_ff    <= exists_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
      end
      mode_ff       <= mode_in;
      slot_ff       <= slot_in;
      amount_ff     <= amount_in;
      value_ff      <= value_in;
      cur_slot_ff   <= cur_slot_in;
      idx_ff        <= idx_in;
      n_total_ff    <= n_total_in;
      emit_cnt_ff   <= emit_cnt_in;
      prev_valid_ff <= prev_valid_in;
      prev_key_ff   <= prev_key_in;
      best_valid_ff <= best_valid_in;
      best_key_ff   <= best_key_in;
      res_status_ff <= res_status_in;
      res_has_ff    <= res_has_in;
      res_data_ff   <= res_data_in;
      res_count_ff  <= res_count_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_has_value = rsp_has_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_count_out = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

   // A read walk never emits more elements than it counted at the start.
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) && res_has_ff |-> (emit_cnt_ff <= n_total_ff))
      else $error("read walk emitted more elements than counted");

   // The current list never holds more elements than its capacity.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      cur_exists |-> (cur_cnt <= cur_cap))
      else $error("list count exceeds capacity");

   // The final transfer of a command returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      load_rsp && res_last_ff |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("sequencer busy after final response");

endmodule

// ===== rtl/core/bmlt_store.sv =====
// Element store of the list table: one write port, one registered read port.
// Depends on bmlt_pkg for the data width.
module bmlt_store
   import bmlt_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for bounded_multi_list_table_top.
// Depends on bmlt_pkg and the top module; predicts every response in-line.
`timescale 1ns / 100ps

module testbench;
   import bmlt_pkg::*;

   localparam int LISTS = 8;
   localparam int CAP_MAX = 8;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [SLOT_W-1:0]          slot;
      logic signed [AMOUNT_W-1:0] amount;
      logic signed [DATA_W-1:0]   value;
   } command_t;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     has_value;
      logic signed [DATA_W-1:0] data;
      logic [CNT_W-1:0]         count;
      logic                     last;
   } answer_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [MODE_W-1:0] req_mode = '0;
   logic [SLOT_W-1:0] req_slot = '0;
   logic signed [AMOUNT_W-1:0] req_amount = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic [STATUS_W-1:0] rsp_status;
   logic rsp_has_value;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic [CNT_W-1:0] rsp_count_out;
   logic rsp_last;

   bounded_multi_list_table_top DUT (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Shadow copy of the table.
   logic        shadow_exists [LISTS];
   int          shadow_cap [LISTS];
   int          shadow_cnt [LISTS];
   logic [31:0] shadow_elem [LISTS][CAP_MAX];

   command_t pending_cmds[$];
   answer_t  expected_answers[$];
   int mismatches = 0;
   bit stimulus_done = 0;
   int hold_off = 0;

   function automatic answer_t one_answer(status_type st, logic hv, logic [31:0] d,
                                          int cnt, logic lst);
      answer_t a;
      a.status = st; a.has_value = hv; a.data = d; a.count = cnt[3:0]; a.last = lst;
      return a;
   endfunction

   function automatic void push_values(logic [31:0] v[$], bit sorted);
      if (sorted) v.sort() with (item ^ 32'h8000_0000);
      foreach (v[i])
         expected_answers.push_back(one_answer(ST_OK, 1, v[i], 0, i == v.size() - 1));
   endfunction

   function automatic void predict_table(command_t c);
      int s, n, newcap, k, amt;
      logic [31:0] vals[$];
      amt = c.amount;
      if (c.mode > MODE_ALL_SORTED) return;
      if (c.mode >= MODE_READ_ALL) begin
         for (s = 0; s < LISTS; s++)
            if (shadow_exists[s])
               for (k = 0; k < shadow_cnt[s]; k++) vals.push_back(shadow_elem[s][k]);
         if (vals.size() == 0) expected_answers.push_back(one_answer(ST_ALL_EMPTY, 0, 0, 0, 1));
         else push_values(vals, c.mode == MODE_ALL_SORTED);
         return;
      end
      if (c.slot < 1 || c.slot > LISTS) begin
         expected_answers.push_back(one_answer(ST_BAD_SLOT, 0, 0, 0, 1));
         return;
      end
      s = c.slot - 1;
      if (c.mode == MODE_CREATE) begin
         if (shadow_exists[s])
            expected_answers.push_back(one_answer(ST_EXISTS, 0, 0, 0, 1));
         else if (amt < 1)
            expected_answers.push_back(one_answer(ST_BAD_SIZE, 0, 0, 0, 1));
         else if (amt > CAP_MAX)
            expected_answers.push_back(one_answer(ST_NO_MEMORY, 0, 0, 0, 1));
         else begin
            shadow_exists[s] = 1; shadow_cap[s] = amt; shadow_cnt[s] = 0;
            expected_answers.push_back(one_answer(ST_OK, 0, 0, 0, 1));
         end
         return;
      end
      if (!shadow_exists[s]) begin
         expected_answers.push_back(one_answer(ST_NO_LIST, 0, 0, 0, 1));
         return;
      end
      n = shadow_cnt[s];
      case (c.mode)
         MODE_APPEND: begin
            if (n >= shadow_cap[s])
               expected_answers.push_back(one_answer(ST_FULL, 0, 0, 0, 1));
            else begin
               shadow_elem[s][n] = c.value; shadow_cnt[s] = n + 1;
               expected_answers.push_back(one_answer(ST_OK, 0, 0, 0, 1));
            end
         end
         MODE_DROP_LAST: begin
            if (n == 0) expected_answers.push_back(one_answer(ST_EMPTY, 0, 0, 0, 1));
            else begin
               shadow_cnt[s] = n - 1;
               expected_answers.push_back(one_answer(ST_OK, 0, 0, 0, 1));
            end
         end
         MODE_DROP_VALUE: begin
            if (n == 0) expected_answers.push_back(one_answer(ST_EMPTY, 0, 0, 0, 1));
            else begin
               k = 0;
               while (k < n && shadow_elem[s][k] != c.value) k++;
               if (k == n) expected_answers.push_back(one_answer(ST_NOT_FOUND, 0, 0, 0, 1));
               else begin
                  for (; k + 1 < n; k++) shadow_elem[s][k] = shadow_elem[s][k + 1];
                  shadow_cnt[s] = n - 1;
                  expected_answers.push_back(one_answer(ST_OK, 0, 0, 0, 1));
               end
            end
         end
         MODE_RESIZE: begin
            newcap = shadow_cap[s] + amt;
            if (newcap < 1)
               expected_answers.push_back(one_answer(ST_BAD_NEW_SIZE, 0, 0, 0, 1));
            else if (newcap > CAP_MAX)
               expected_answers.push_back(one_answer(ST_NO_MEMORY, 0, 0, 0, 1));
            else begin
               shadow_cap[s] = newcap;
               if (n > newcap) shadow_cnt[s] = newcap;
               expected_answers.push_back(one_answer(ST_OK, 0, 0, 0, 1));
            end
         end
         MODE_COUNT: begin
            if (n == 0) expected_answers.push_back(one_answer(ST_EMPTY, 0, 0, 0, 1));
            else expected_answers.push_back(one_answer(ST_OK, 0, 0, n, 1));
         end
         default: begin
            if (n == 0) expected_answers.push_back(one_answer(ST_OK, 0, 0, 0, 1));
            else begin
               for (k = 0; k < n; k++) vals.push_back(shadow_elem[s][k]);
               push_values(vals, c.mode == MODE_READ_SORTED);
            end
         end
      endcase
   endfunction

   function automatic command_t make_cmd(mode_type m, int sl, int amt, logic [31:0] v);
      command_t c;
      c.mode = m; c.slot = sl[3:0]; c.amount = amt[5:0]; c.value = v;
      return c;
   endfunction

   // Values are drawn from a small pool most of the time so drops find matches.
   function automatic logic [31:0] pick_value();
      logic [31:0] pool[6] = '{32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff, 5, 32'h1234_5678};
      if ($urandom_range(0, 2) == 0) return $urandom;
      return pool[$urandom_range(0, 5)];
   endfunction

   initial begin
      int i;
      for (i = 0; i < LISTS; i++) begin
         shadow_exists[i] = 0; shadow_cap[i] = 0; shadow_cnt[i] = 0;
      end
      // Directed part: every error code and both extremes of each field.
      pending_cmds.push_back(make_cmd(MODE_READ_ALL, 0, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_CREATE, 0, 3, 0));
      pending_cmds.push_back(make_cmd(MODE_CREATE, 15, 3, 0));
      pending_cmds.push_back(make_cmd(MODE_APPEND, 2, 0, 1));
      pending_cmds.push_back(make_cmd(MODE_CREATE, 1, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_CREATE, 1, -32, 0));
      pending_cmds.push_back(make_cmd(MODE_CREATE, 1, 31, 0));
      pending_cmds.push_back(make_cmd(MODE_CREATE, 1, 2, 0));
      pending_cmds.push_back(make_cmd(MODE_CREATE, 1, 2, 0));
      pending_cmds.push_back(make_cmd(MODE_READ, 1, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_COUNT, 1, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_DROP_LAST, 1, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_DROP_VALUE, 1, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_READ_ALL, 0, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_APPEND, 1, 0, 32'h7fff_ffff));
      pending_cmds.push_back(make_cmd(MODE_APPEND, 1, 0, 32'h8000_0000));
      pending_cmds.push_back(make_cmd(MODE_APPEND, 1, 0, 3));
      pending_cmds.push_back(make_cmd(MODE_READ_SORTED, 1, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_DROP_VALUE, 1, 0, 9));
      pending_cmds.push_back(make_cmd(MODE_RESIZE, 1, 6, 0));
      pending_cmds.push_back(make_cmd(MODE_RESIZE, 1, 7, 0));
      pending_cmds.push_back(make_cmd(MODE_RESIZE, 1, -8, 0));
      pending_cmds.push_back(make_cmd(MODE_RESIZE, 1, -7, 0));
      pending_cmds.push_back(make_cmd(15, 1, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_ALL_SORTED, 0, 0, 0));
      // Random part: mostly legal slots, weighted toward append and reads.
      for (i = 0; i < 460; i++) begin
         int r, m, sl;
         r = $urandom_range(0, 99);
         if (r < 8) m = MODE_CREATE;
         else if (r < 40) m = MODE_APPEND;
         else if (r < 47) m = MODE_DROP_LAST;
         else if (r < 57) m = MODE_DROP_VALUE;
         else if (r < 64) m = MODE_RESIZE;
         else if (r < 70) m = MODE_COUNT;
         else if (r < 78) m = MODE_READ;
         else if (r < 86) m = MODE_READ_SORTED;
         else if (r < 91) m = MODE_READ_ALL;
         else if (r < 96) m = MODE_ALL_SORTED;
         else m = $urandom_range(0, 15);
         sl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, LISTS);
         pending_cmds.push_back(make_cmd(m, sl,
            ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $signed($urandom_range(0, 20)) - 10,
            pick_value()));
      end
      stimulus_done = 1;
   end

   // Driver.
   int send_gap = 0;
   int sent = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && !req_stall) begin
         predict_table({req_mode, req_slot, req_amount, req_value});
         sent <= sent + 1;
         send_gap = $urandom_range(0, 6);
         if (send_gap == 0 && pending_cmds.size() > 0) begin
            command_t c;
            c = pending_cmds.pop_front();
            {req_mode, req_slot, req_amount, req_value} <= c;
         end else begin
            req_valid <= 0;
         end
      end else if (!req_valid) begin
         if (send_gap > 0) send_gap--;
         else if (pending_cmds.size() > 0) begin
            command_t c;
            c = pending_cmds.pop_front();
            {req_mode, req_slot, req_amount, req_value} <= c;
            req_valid <= 1;
         end
      end
   end

   // Receiver: random stalls plus one long hold-off early in the random part.
   int recv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1;
      end else if (sent == 40 && hold_off == 0) begin
         hold_off <= 1;
         rsp_stall <= 1;
      end else if (hold_off > 0 && hold_off < 300) begin
         hold_off <= hold_off + 1;
         rsp_stall <= 1;
      end else begin
         if (rsp_valid && !rsp_stall) recv_gap = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0 && sent > 300) recv_gap = 0;
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         answer_t want;
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: status %0d data %0h",
                                          rsp_status, rsp_data_out);
         end else begin
            want = expected_answers.pop_front();
            if (want != {rsp_status, rsp_has_value, rsp_data_out, rsp_count_out, rsp_last}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d hv %0b d %0h c %0d l %0b, got st %0d hv %0b d %0h c %0d l %0b",
                     want.status, want.has_value, want.data, want.count, want.last,
                     rsp_status, rsp_has_value, rsp_data_out, rsp_count_out, rsp_last);
            end
         end
      end
   end

   // Watchdog and end of run.
   int idle_cycles = 0;
   initial begin
      int tail;
      repeat (11) @(posedge clock);
      reset <= 0;
      while (!(stimulus_done && pending_cmds.size() == 0 && !req_valid
               && expected_answers.size() == 0)) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
      tail = 0;
      while (tail < 600) begin
         @(posedge clock);
         tail++;
      end
      if (mismatches == 0 && expected_answers.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
